/* rtl/pidmd_pkg.sv */
// ============================================================================
// pidmd_pkg
// Shared types, codes and the control program of the PID motor drive core.
// ============================================================================
package pidmd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DRIVE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W    = 3;
    localparam int ACC_W     = 52;
    localparam int PROD_W    = 64;
    localparam int TOT_W     = 18;

    // Q16 value of 1.0
    localparam logic signed [TOT_W-1:0] ONE_Q16 = 18'sd65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER  = 3'd6;

    // Reset values
    localparam logic signed [15:0] RST_TARGET    = 16'sd0;
    localparam logic [14:0]        RST_DEADBAND  = 15'd10;
    localparam logic [16:0]        RST_INT_LIMIT = 17'd65536;
    localparam logic signed [31:0] RST_GAIN      = 32'sd0;
    localparam logic [6:0]         RST_MAX_POWER = 7'd127;

    // Program step addresses
    localparam logic [STEP_W-1:0] S_WAIT  = 3'd0;
    localparam logic [STEP_W-1:0] S_ERR   = 3'd1;
    localparam logic [STEP_W-1:0] S_STATE = 3'd2;
    localparam logic [STEP_W-1:0] S_MUL_I = 3'd3;
    localparam logic [STEP_W-1:0] S_MUL_D = 3'd4;
    localparam logic [STEP_W-1:0] S_TOTAL = 3'd5;
    localparam logic [STEP_W-1:0] S_SCALE = 3'd6;
    localparam logic [STEP_W-1:0] S_EMIT  = 3'd7;

    typedef enum logic [1:0] {
        A_ERR   = 2'd0,
        A_SUM   = 2'd1,
        A_DERIV = 2'd2,
        A_TOT   = 2'd3
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        B_PROP  = 2'd0,
        B_INTEG = 2'd1,
        B_DERIV = 2'd2,
        B_POWER = 2'd3
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD_IC = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic       wait_in;
        logic       wait_out;
        logic       load_in;
        logic       calc_err;
        logic       upd_state;
        logic       mul_en;
        mul_a_sel_t a_sel;
        mul_b_sel_t b_sel;
        acc_op_t    acc_op;
        logic       clamp_tot;
        logic       emit;
        logic       last;
    } ctrl_t;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic [14:0]        deadband;
        logic [16:0]        integral_limit;
        logic signed [31:0] gain_prop;
        logic signed [31:0] gain_integ;
        logic signed [31:0] gain_deriv;
        logic [6:0]         max_power;
    } cfg_t;

    // Control store: one word per step
    function automatic ctrl_t prog_word(logic [STEP_W-1:0] addr);
        ctrl_t w;
        w = '{wait_in: 1'b0, wait_out: 1'b0, load_in: 1'b0, calc_err: 1'b0,
              upd_state: 1'b0, mul_en: 1'b0, a_sel: A_ERR, b_sel: B_PROP,
              acc_op: ACC_NONE, clamp_tot: 1'b0, emit: 1'b0, last: 1'b0};
        unique case (addr)
            S_WAIT: begin
                w.wait_in = 1'b1;
                w.load_in = 1'b1;
            end
            S_ERR: begin
                w.calc_err = 1'b1;
            end
            S_STATE: begin
                w.upd_state = 1'b1;
                w.mul_en    = 1'b1;
                w.a_sel     = A_ERR;
                w.b_sel     = B_PROP;
            end
            S_MUL_I: begin
                w.mul_en = 1'b1;
                w.a_sel  = A_SUM;
                w.b_sel  = B_INTEG;
                w.acc_op = ACC_LOAD;
            end
            S_MUL_D: begin
                w.mul_en = 1'b1;
                w.a_sel  = A_DERIV;
                w.b_sel  = B_DERIV;
                w.acc_op = ACC_ADD_IC;
            end
            S_TOTAL: begin
                w.clamp_tot = 1'b1;
            end
            S_SCALE: begin
                w.mul_en = 1'b1;
                w.a_sel  = A_TOT;
                w.b_sel  = B_POWER;
            end
            S_EMIT: begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.last     = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/pidmd_datapath.sv */
// ============================================================================
// pidmd_datapath
// Error, integral and derivative registers, a shared 32x32 multiplier and
// the accumulator with its clamps; one control word per advancing cycle.
// ============================================================================
module pidmd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pidmd_pkg::ctrl_t                    ctrl,
    input  logic                                advance,
    input  logic signed [pidmd_pkg::SAMPLE_W-1:0] sample,
    input  pidmd_pkg::cfg_t                     cfg,
    output logic signed [pidmd_pkg::DRIVE_W-1:0]  drive
);

    logic signed [15:0] sample_reg;
    logic signed [15:0] err_reg, err_next;
    logic signed [15:0] prev_err_reg;
    logic signed [31:0] error_sum_reg, error_sum_next;
    logic signed [16:0] deriv_reg, deriv_next;
    logic signed [pidmd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [pidmd_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [pidmd_pkg::TOT_W-1:0]  tot_reg, tot_next;

    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic signed [32:0] sum_ext;
    logic signed [31:0] mul_a, mul_b;
    logic signed [pidmd_pkg::PROD_W-1:0] lim_pos, lim_neg, iterm;
    logic signed [pidmd_pkg::ACC_W-1:0]  total;
    logic signed [24:0] scaled;

    function automatic logic signed [16:0] target_ext(logic signed [15:0] v);
        return {v[15], v};
    endfunction

    // Error: exact 17-bit difference, deadband, then saturate to 16 bits
    always_comb begin
        diff = 17'(target_ext(cfg.setpoint)) - 17'(target_ext(sample_reg));
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        if (mag < {2'b00, cfg.deadband}) begin
            err_next = 16'sd0;
        end else if (diff > 17'sd32767) begin
            err_next = 16'sh7FFF;
        end else if (diff < -17'sd32768) begin
            err_next = 16'sh8000;
        end else begin
            err_next = diff[15:0];
        end
    end

    // Saturating integral and exact derivative
    always_comb begin
        sum_ext = {error_sum_reg[31], error_sum_reg} + 33'(err_reg);
        if (sum_ext > 33'sh0_7FFF_FFFF) begin
            error_sum_next = 32'sh7FFF_FFFF;
        end else if (sum_ext < -33'sh0_8000_0000) begin
            error_sum_next = 32'sh8000_0000;
        end else begin
            error_sum_next = sum_ext[31:0];
        end
        deriv_next = 17'(err_reg) - 17'(prev_err_reg);
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (ctrl.a_sel)
            pidmd_pkg::A_ERR:   mul_a = 32'(err_reg);
            pidmd_pkg::A_SUM:   mul_a = error_sum_reg;
            pidmd_pkg::A_DERIV: mul_a = 32'(deriv_reg);
            pidmd_pkg::A_TOT:   mul_a = 32'(tot_reg);
            default:            mul_a = 32'sd0;
        endcase
        unique case (ctrl.b_sel)
            pidmd_pkg::B_PROP:  mul_b = cfg.gain_prop;
            pidmd_pkg::B_INTEG: mul_b = cfg.gain_integ;
            pidmd_pkg::B_DERIV: mul_b = cfg.gain_deriv;
            pidmd_pkg::B_POWER: mul_b = {25'd0, cfg.max_power};
            default:            mul_b = 32'sd0;
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // Integral term clamp and accumulation
    always_comb begin
        lim_pos = {47'd0, cfg.integral_limit};
        lim_neg = -lim_pos;
        if (prod_reg > lim_pos) begin
            iterm = lim_pos;
        end else if (prod_reg < lim_neg) begin
            iterm = lim_neg;
        end else begin
            iterm = prod_reg;
        end
        unique case (ctrl.acc_op)
            pidmd_pkg::ACC_LOAD:   acc_next = prod_reg[pidmd_pkg::ACC_W-1:0];
            pidmd_pkg::ACC_ADD_IC: acc_next = acc_reg + iterm[pidmd_pkg::ACC_W-1:0];
            default:               acc_next = acc_reg;
        endcase
        total = acc_reg + prod_reg[pidmd_pkg::ACC_W-1:0];
        if (total > pidmd_pkg::ACC_W'(pidmd_pkg::ONE_Q16)) begin
            tot_next = pidmd_pkg::ONE_Q16;
        end else if (total < -pidmd_pkg::ACC_W'(pidmd_pkg::ONE_Q16)) begin
            tot_next = -pidmd_pkg::ONE_Q16;
        end else begin
            tot_next = total[pidmd_pkg::TOT_W-1:0];
        end
    end

    // Scale by max power and divide by 2^16, truncating toward zero
    always_comb begin
        scaled = prod_reg[24:0] + (prod_reg[24] ? 25'sd65535 : 25'sd0);
        drive  = scaled[23:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg <= 32'sd0;
            prev_err_reg  <= 16'sd0;
        end else if (advance && ctrl.upd_state) begin
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctrl.load_in) begin
            sample_reg <= sample;
        end
        if (advance && ctrl.calc_err) begin
            err_reg <= err_next;
        end
        if (advance && ctrl.upd_state) begin
            deriv_reg <= deriv_next;
        end
        if (advance && ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (advance) begin
            acc_reg <= acc_next;
        end
        if (advance && ctrl.clamp_tot) begin
            tot_reg <= tot_next;
        end
    end

endmodule

/* rtl/pid_motor_drive_core.sv */
// ============================================================================
// pid_motor_drive_core
// Fixed-point PID controller with deadband and integral clamp, run by a
// small microcoded sequencer over a shared multiplier datapath.
// ============================================================================
//
//  channel   ports                               direction  word
//  --------  ----------------------------------  ---------  ---------------------
//  sample    s_valid s_ready s_sensor_sample     in         signed 16-bit sample
//  drive     m_valid m_ready m_motor_drive       out        signed 8-bit command
//  config    cfg_wr_en cfg_index cfg_wdata       in         register write
//
// Each sample runs the 8-word control program, one step per cycle unless a
// wait step holds for its handshake; the single 32x32 multiplier forms the
// P, I, D and scaling products in turn. The drive word sits in an output
// register, so the next sample is taken while the last word still waits for
// m_ready; only a second finished word stalls the program at its last step.
// Reset (aresetn low at a clock edge) clears the integral, the previous
// error, the program counter and the output valid, and loads the register
// defaults.
// ============================================================================
module pid_motor_drive_core (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // sample channel
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [pidmd_pkg::SAMPLE_W-1:0]    s_sensor_sample,
    // drive channel
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [pidmd_pkg::DRIVE_W-1:0]     m_motor_drive,
    // configuration
    input  logic                                     cfg_wr_en,
    input  logic [pidmd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pidmd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    logic [pidmd_pkg::STEP_W-1:0] step_reg, step_next;
    pidmd_pkg::ctrl_t             ctrl;
    pidmd_pkg::cfg_t              cfg_reg;
    logic                         advance;
    logic                         out_free;
    logic                         m_valid_reg, m_valid_next;
    logic signed [pidmd_pkg::DRIVE_W-1:0] m_drive_reg;
    logic signed [pidmd_pkg::DRIVE_W-1:0] dp_drive;

    // Fetch the control word for the current step
    assign ctrl = pidmd_pkg::prog_word(step_reg);

    // Output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // Hold on the wait steps until their handshake side is ready
    always_comb begin
        priority if (ctrl.wait_in) begin
            advance = s_valid;
        end else if (ctrl.wait_out) begin
            advance = out_free;
        end else begin
            advance = 1'b1;
        end
    end

    assign s_ready = ctrl.wait_in;

    // Advance the step counter, jump back to the start after the last word
    always_comb begin
        if (!advance) begin
            step_next = step_reg;
        end else if (ctrl.last) begin
            step_next = pidmd_pkg::S_WAIT;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pidmd_pkg::S_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // Configuration registers; drop writes to unused indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint       <= pidmd_pkg::RST_TARGET;
            cfg_reg.deadband       <= pidmd_pkg::RST_DEADBAND;
            cfg_reg.integral_limit <= pidmd_pkg::RST_INT_LIMIT;
            cfg_reg.gain_prop      <= pidmd_pkg::RST_GAIN;
            cfg_reg.gain_integ     <= pidmd_pkg::RST_GAIN;
            cfg_reg.gain_deriv     <= pidmd_pkg::RST_GAIN;
            cfg_reg.max_power      <= pidmd_pkg::RST_MAX_POWER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidmd_pkg::REG_TARGET:     cfg_reg.setpoint       <= cfg_wdata[15:0];
                pidmd_pkg::REG_DEADBAND:   cfg_reg.deadband       <= cfg_wdata[14:0];
                pidmd_pkg::REG_INT_LIMIT:  cfg_reg.integral_limit <= cfg_wdata[16:0];
                pidmd_pkg::REG_GAIN_PROP:  cfg_reg.gain_prop      <= cfg_wdata;
                pidmd_pkg::REG_GAIN_INTEG: cfg_reg.gain_integ     <= cfg_wdata;
                pidmd_pkg::REG_GAIN_DERIV: cfg_reg.gain_deriv     <= cfg_wdata;
                pidmd_pkg::REG_MAX_POWER:  cfg_reg.max_power      <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    pidmd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .advance (advance),
        .sample  (s_sensor_sample),
        .cfg     (cfg_reg),
        .drive   (dp_drive)
    );

    // Output register: load on the emit step, clear once the word is taken
    always_comb begin
        if (ctrl.emit && advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && advance) begin
            m_drive_reg <= dp_drive;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_motor_drive = m_drive_reg;

endmodule

/* bench/testbench.sv */
// ============================================================================
// PID motor drive core testbench
// Drives sensor samples through the core under random and directed register
// settings, predicts every drive word with an independent fixed-point model
// of the controller, and compares each word the core hands back in order.
// ============================================================================
module testbench;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [pidmd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // Cycles to let pass once all expected words are home
    localparam int SETTLE_CYCLES = 12;

    // Bounds of the 32-bit saturating integral
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    // Random phases and their length
    localparam int RAND_PHASES = 8;
    localparam int RAND_WORDS  = 147;

    logic                                   aclk            = 1'b0;
    logic                                   aresetn         = 1'b0;
    logic                                   s_valid         = 1'b0;
    logic                                   s_ready;
    logic signed [pidmd_pkg::SAMPLE_W-1:0]  s_sensor_sample = '0;
    logic                                   m_valid;
    logic                                   m_ready         = 1'b0;
    logic signed [pidmd_pkg::DRIVE_W-1:0]   m_motor_drive;
    logic                                   cfg_wr_en       = 1'b0;
    logic [pidmd_pkg::CFG_IDX_W-1:0]        cfg_index       = '0;
    logic [pidmd_pkg::CFG_DATA_W-1:0]       cfg_wdata       = '0;

    // Samples waiting to be offered, and drive words the core still owes
    logic signed [pidmd_pkg::SAMPLE_W-1:0]  sample_queue[$];
    logic signed [pidmd_pkg::DRIVE_W-1:0]   drive_expect[$];

    // Controller copy: register file and loop state
    pidmd_pkg::cfg_t                        model_cfg;
    logic signed [31:0]                     integ_acc;
    logic signed [15:0]                     hist_error;

    // Set while both sides must run without idling
    bit                                     steady = 1'b0;
    int unsigned                            error_count = 0;

    pid_motor_drive_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_sample (s_sensor_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_motor_drive   (m_motor_drive),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Controller prediction
    // ------------------------------------------------------------------------
    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the loop state by one sample and return the drive word it gives
    function automatic logic signed [pidmd_pkg::DRIVE_W-1:0] pid_step(
        logic signed [pidmd_pkg::SAMPLE_W-1:0] sample);
        longint err, mag, sum, iterm, slope, total, lim;
        // Error is exact over 17 bits here; deadband test comes before saturation
        err = longint'(model_cfg.setpoint) - longint'(sample);
        mag = (err < 0) ? -err : err;
        if (mag < longint'(model_cfg.deadband)) err = 0;
        err = bound(err, -32768, 32767);

        sum = bound(longint'(integ_acc) + err, ACC_MIN, ACC_MAX);
        integ_acc = sum[31:0];

        lim = longint'(model_cfg.integral_limit);
        iterm = bound(longint'(integ_acc) * longint'(model_cfg.gain_integ), -lim, lim);

        // Derivative is kept unwrapped; the saturated error becomes the history
        slope = err - longint'(hist_error);
        hist_error = err[15:0];

        total = err * longint'(model_cfg.gain_prop) + iterm
              + slope * longint'(model_cfg.gain_deriv);
        total = bound(total, -longint'(pidmd_pkg::ONE_Q16), longint'(pidmd_pkg::ONE_Q16));
        // Signed division truncates toward zero
        total = (total * longint'(model_cfg.max_power)) / longint'(pidmd_pkg::ONE_Q16);
        return total[pidmd_pkg::DRIVE_W-1:0];
    endfunction

    function automatic void apply_reg(logic [pidmd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [pidmd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pidmd_pkg::REG_TARGET:     model_cfg.setpoint       = data[15:0];
            pidmd_pkg::REG_DEADBAND:   model_cfg.deadband       = data[14:0];
            pidmd_pkg::REG_INT_LIMIT:  model_cfg.integral_limit = data[16:0];
            pidmd_pkg::REG_GAIN_PROP:  model_cfg.gain_prop      = data;
            pidmd_pkg::REG_GAIN_INTEG: model_cfg.gain_integ     = data;
            pidmd_pkg::REG_GAIN_DERIV: model_cfg.gain_deriv     = data;
            pidmd_pkg::REG_MAX_POWER:  model_cfg.max_power      = data[6:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Fill the bits above a narrow register with junk; the core must drop them
    function automatic logic [31:0] pad_word(logic [31:0] value, int width);
        logic [31:0] mask;
        mask = 32'((64'd1 << width) - 1);
        return (value & mask) | ($urandom & ~mask);
    endfunction

    // Signed Q15.16 gain with a random magnitude scale, extremes now and then
    function automatic logic [31:0] random_gain();
        int unsigned bits;
        logic [31:0] mag;
        case ($urandom_range(9, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: begin
                bits = $urandom_range(20, 0);
                mag  = $urandom & 32'((64'd1 << bits) - 1);
                return $urandom_range(1, 0) ? -mag : mag;
            end
        endcase
    endfunction

    // Sample placed around the current target, near the deadband edge, or anywhere
    function automatic logic signed [15:0] random_sample();
        int t, off, bits;
        t = int'(model_cfg.setpoint);
        case ($urandom_range(9, 0))
            0, 1, 2: return 16'($urandom);
            3: begin
                off = int'(model_cfg.deadband) - int'($urandom_range(1, 0));
            end
            default: begin
                bits = $urandom_range(16, 0);
                off  = int'($urandom & 32'((64'd1 << bits) - 1));
            end
        endcase
        if ($urandom_range(1, 0)) off = -off;
        return 16'(int'(bound(longint'(t + off), -32768, 32767)));
    endfunction

    task automatic write_reg(logic [pidmd_pkg::CFG_IDX_W-1:0] idx,
                             logic [pidmd_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        apply_reg(idx, data);
    endtask

    // Write the whole register file, plus one stray write to the unused index
    task automatic configure(logic signed [15:0] tv, logic [14:0] db, logic [16:0] il,
                             logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [6:0] mp);
        write_reg(pidmd_pkg::REG_TARGET,     pad_word(32'(tv), 16));
        write_reg(pidmd_pkg::REG_DEADBAND,   pad_word(32'(db), 15));
        write_reg(pidmd_pkg::REG_INT_LIMIT,  pad_word(32'(il), 17));
        write_reg(pidmd_pkg::REG_GAIN_PROP,  gp);
        write_reg(pidmd_pkg::REG_GAIN_INTEG, gi);
        write_reg(pidmd_pkg::REG_GAIN_DERIV, gd);
        write_reg(pidmd_pkg::REG_MAX_POWER,  pad_word(32'(mp), 7));
        write_reg(REG_SPARE,                 $urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every sample is taken and every drive word is back, then idle
    task automatic settle();
        while (sample_queue.size() != 0 || drive_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: hold a word until taken, then offer the next or idle
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                drive_expect.push_back(pid_step(s_sensor_sample));
                void'(sample_queue.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && (steady || $urandom_range(99, 0) >= 19)) begin
                    s_valid         <= 1'b1;
                    s_sensor_sample <= sample_queue[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive monitor: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_monitor
        logic signed [pidmd_pkg::DRIVE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expect.size() == 0) begin
                error_count++;
                if (error_count < 100)
                    $display("%0t: motor_drive %0d arrived with nothing expected",
                             $time, m_motor_drive);
            end else begin
                want = drive_expect.pop_front();
                if (m_motor_drive !== want) begin
                    error_count++;
                    if (error_count < 100)
                        $display("%0t: motor_drive mismatch: expected %0d, actual %0d",
                                 $time, want, m_motor_drive);
                end
            end
        end
        m_ready <= steady || ($urandom_range(99, 0) >= 19);
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int p, k;
        logic signed [15:0] tv;
        logic [14:0]        db;
        logic [16:0]        il;
        logic [6:0]         mp;

        model_cfg = '{setpoint: pidmd_pkg::RST_TARGET,
                      deadband: pidmd_pkg::RST_DEADBAND,
                      integral_limit: pidmd_pkg::RST_INT_LIMIT,
                      gain_prop: pidmd_pkg::RST_GAIN,
                      gain_integ: pidmd_pkg::RST_GAIN,
                      gain_deriv: pidmd_pkg::RST_GAIN,
                      max_power: pidmd_pkg::RST_MAX_POWER};
        integ_acc  = '0;
        hist_error = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Deadband edges, sign of truncation, full-scale samples
        configure(16'sd0, 15'd10, 17'd65536, 32'd1024, 32'd1, 32'd256, 7'd127);
        sample_queue = '{16'sd0, -16'sd9, 16'sd9, -16'sd10, 16'sd10, -16'sd11,
                         16'sh7FFF, 16'sh8000, -16'sd32767, 16'sd1234};
        settle();

        // Error beyond 16 bits on the positive side, extreme gains, limit above 1.0
        configure(16'sh7FFF, 15'd0, 17'd131071, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd0, 7'd127);
        sample_queue = '{16'sh8000, 16'sh7FFF, 16'sd0};
        settle();

        // Negative overflow of the error, widest deadband, unwrapped derivative
        configure(16'sh8000, 15'd32767, 17'd0, 32'd1, 32'd0, 32'd1, 7'd127);
        sample_queue = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, -16'sd2};
        settle();

        // Zero max power holds the drive at zero
        configure(16'sd100, 15'd0, 17'd65536, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 7'd0);
        sample_queue = '{16'sh8000, 16'sh7FFF, 16'sd5};
        settle();

        // Random register settings, one run of random samples under each
        for (p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(4, 0))
                0: tv = 16'sh8000;
                1: tv = 16'sh7FFF;
                default: tv = 16'($urandom);
            endcase
            case ($urandom_range(5, 0))
                0: db = 15'd0;
                1: db = 15'd32767;
                2, 3: db = 15'($urandom_range(64, 0));
                default: db = 15'($urandom_range(32767, 0));
            endcase
            case ($urandom_range(5, 0))
                0: il = 17'd0;
                1: il = 17'd65536;
                2: il = 17'd131071;
                default: il = 17'($urandom_range(131071, 0));
            endcase
            case ($urandom_range(5, 0))
                0: mp = 7'd0;
                1: mp = 7'd127;
                default: mp = 7'($urandom_range(127, 0));
            endcase
            configure(tv, db, il, random_gain(), random_gain(), random_gain(), mp);
            steady = (p == 3);
            for (k = 0; k < RAND_WORDS; k++) sample_queue.push_back(random_sample());
            settle();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (drive_expect.size() != 0) begin
            error_count++;
            $display("%0t: %0d drive words never arrived", $time, drive_expect.size());
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
